>>> rtl/dtic_pkg.sv
// Package for the dual timer interrupt controller.
// Holds operation codes, register offsets, bit positions and constants.
// No dependencies.
package dtic_pkg;

    // Beat operation codes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Register offsets.
    localparam logic [3:0] REG_TA_LO = 4'd4;
    localparam logic [3:0] REG_TA_HI = 4'd5;
    localparam logic [3:0] REG_TB_LO = 4'd6;
    localparam logic [3:0] REG_TB_HI = 4'd7;
    localparam logic [3:0] REG_ICR   = 4'd13;
    localparam logic [3:0] REG_CRA   = 4'd14;
    localparam logic [3:0] REG_CRB   = 4'd15;

    // Control register bit positions.
    localparam int CR_START   = 0;
    localparam int CR_ONESHOT = 3;
    localparam int CR_LOAD    = 4;

    // Interrupt status and mask constants.
    localparam logic [7:0] IRQ_TA     = 8'h81;
    localparam logic [7:0] IRQ_TB     = 8'h82;
    localparam logic [7:0] IRQ_FLAG   = 8'h90;
    localparam logic [7:0] IRQ_SRCS   = 8'h1F;
    localparam int         ICR_SET    = 7;

    // Input beat fields.
    typedef struct packed {
        logic       flag_edge;
        logic [7:0] write_data;
        logic [3:0] reg_offset;
        logic [1:0] opcode;
    } t_in_item;

    // Result beat fields.
    typedef struct packed {
        logic       irq;
        logic [7:0] read_data;
    } t_out_item;

endpackage

>>> rtl/dual_timer_interrupt_controller.sv
// Dual timer interrupt controller top level.
// Two 16-bit down counters, interrupt status and mask, streaming ports.
// Depends on dtic_pkg.
//
// Each input beat is a register read, a register write or one timer tick.
// The block takes one beat in every clock cycle unless the input stalls: all
// state updates for a beat are done in combinational logic feeding the timer,
// control and interrupt registers, and its result is registered in the output
// register, or in the skid register while the output is held. A two-entry
// output buffer (output register plus skid register) lets a new beat be taken
// while a finished result still waits; the input stalls only when both
// entries are full. Reading the interrupt status returns it, clears it and
// drops irq; irq rises only on a tick.
module dual_timer_interrupt_controller
    import dtic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beats.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] opcode, [5:2] reg_offset, [13:6] write_data, [14] flag_edge,
    // [15] zero.
    input  logic [15:0] i_s_axis_tdata,
    // Result beats.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] read_data, [8] irq, [15:9] zero.
    output logic [15:0] o_m_axis_tdata
);

    // Architectural state.
    logic [15:0] r_count_a, r_count_b, r_latch_a, r_latch_b;
    logic [7:0]  r_ctrl_a, r_ctrl_b, r_mask, r_status;
    logic        r_irq;
    logic [15:0] n_count_a, n_count_b, n_latch_a, n_latch_b;
    logic [7:0]  n_ctrl_a, n_ctrl_b, n_mask, n_status;
    logic        n_irq;

    // Output buffer.
    logic        r_out_valid, r_skid_valid;
    t_out_item   r_out, r_skid;

    t_in_item    in_item;
    t_out_item   result;
    logic        accept;
    logic        pop;
    logic        out_free;
    logic [15:0] dec_a, dec_b;

    assign in_item         = t_in_item'(i_s_axis_tdata[14:0]);
    assign o_s_axis_tready = ~r_skid_valid;
    assign accept          = i_s_axis_tvalid & ~r_skid_valid;
    assign pop             = r_out_valid & i_m_axis_tready;
    assign out_free        = ~r_out_valid | pop;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out};

    assign dec_a = r_count_a - 16'd1;

    // Next state and result for the beat on the input.
    always_comb begin
        n_count_a = r_count_a;
        n_count_b = r_count_b;
        n_latch_a = r_latch_a;
        n_latch_b = r_latch_b;
        n_ctrl_a  = r_ctrl_a;
        n_ctrl_b  = r_ctrl_b;
        n_mask    = r_mask;
        n_status  = r_status;
        n_irq     = r_irq;
        result    = '0;
        dec_b     = r_count_b - 16'd1;

        case (in_item.opcode)
            OP_READ: begin
                case (in_item.reg_offset)
                    REG_TA_LO: result.read_data = r_count_a[7:0];
                    REG_TA_HI: result.read_data = r_count_a[15:8];
                    REG_TB_LO: result.read_data = r_count_b[7:0];
                    REG_TB_HI: result.read_data = r_count_b[15:8];
                    REG_ICR: begin
                        result.read_data = r_status;
                        n_status         = '0;
                        n_irq            = 1'b0;
                    end
                    REG_CRA:   result.read_data = r_ctrl_a;
                    REG_CRB:   result.read_data = r_ctrl_b;
                    default:   result.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (in_item.reg_offset)
                    REG_TA_LO: n_latch_a[7:0]  = in_item.write_data;
                    REG_TA_HI: n_latch_a[15:8] = in_item.write_data;
                    REG_TB_LO: n_latch_b[7:0]  = in_item.write_data;
                    REG_TB_HI: n_latch_b[15:8] = in_item.write_data;
                    REG_ICR: begin
                        if (in_item.write_data[ICR_SET]) begin
                            n_mask = r_mask | in_item.write_data;
                        end else begin
                            n_mask = r_mask & ~in_item.write_data;
                        end
                    end
                    REG_CRA: begin
                        n_ctrl_a = in_item.write_data;
                        if (in_item.write_data[CR_LOAD]) begin
                            n_count_a = r_latch_a;
                        end
                    end
                    REG_CRB: begin
                        n_ctrl_b = in_item.write_data;
                        if (in_item.write_data[CR_LOAD]) begin
                            n_count_b = r_latch_b;
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                // Flag edge first, then timer A, then timer B.
                if (in_item.flag_edge) begin
                    n_status = n_status | IRQ_FLAG;
                end
                if (r_ctrl_a[CR_START]) begin
                    if (r_count_a == 16'd0) begin
                        n_status  = n_status | IRQ_TA;
                        n_count_a = r_latch_a;
                        if (r_ctrl_a[CR_ONESHOT]) begin
                            n_ctrl_a[CR_START] = 1'b0;
                        end
                    end else begin
                        n_count_a = dec_a;
                    end
                end
                if (r_ctrl_b[CR_START]) begin
                    if (r_count_b == 16'd0) begin
                        n_status  = n_status | IRQ_TB;
                        n_count_b = r_latch_b;
                        if (r_ctrl_b[CR_ONESHOT]) begin
                            n_ctrl_b[CR_START] = 1'b0;
                        end
                    end else begin
                        n_count_b = dec_b;
                    end
                end
                // The request line is sticky until a status read.
                if ((n_status & r_mask & IRQ_SRCS) != 8'd0) begin
                    n_irq = 1'b1;
                end
            end
            default: ;
        endcase
        result.irq = n_irq;
    end

    // State registers, updated on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a <= '0;
            r_count_b <= '0;
            r_latch_a <= '0;
            r_latch_b <= '0;
            r_ctrl_a  <= '0;
            r_ctrl_b  <= '0;
            r_mask    <= '0;
            r_status  <= '0;
            r_irq     <= 1'b0;
        end else if (accept) begin
            r_count_a <= n_count_a;
            r_count_b <= n_count_b;
            r_latch_a <= n_latch_a;
            r_latch_b <= n_latch_b;
            r_ctrl_a  <= n_ctrl_a;
            r_ctrl_b  <= n_ctrl_b;
            r_mask    <= n_mask;
            r_status  <= n_status;
            r_irq     <= n_irq;
        end
    end

    // Output register and skid register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= accept;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (accept) begin
                    r_skid <= result;
                end
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

endmodule
